// ----- design/one_wire_bus_master_core_defines.svh -----
// Assertion macros shared by the one-wire bus master RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ONE_WIRE_BUS_MASTER_CORE_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_CORE_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define OWBM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define OWBM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/owbm_pkg.sv -----
// Types and constants of the one-wire bus master.
// No dependencies; imported by owbm_cfg_regs, owbm_step, the top level and the bench.
`timescale 1ns / 1ps

package owbm_pkg;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_RESET = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } owbm_action_t;

    typedef enum logic [10:0] {
        PH_IDLE      = 11'b000_0000_0001,
        PH_RST_LOW   = 11'b000_0000_0010,
        PH_RST_DELAY = 11'b000_0000_0100,
        PH_RST_WAIT  = 11'b000_0000_1000,
        PH_RST_MEAS  = 11'b000_0001_0000,
        PH_RST_POST  = 11'b000_0010_0000,
        PH_WR_LOW    = 11'b000_0100_0000,
        PH_WR_REC    = 11'b000_1000_0000,
        PH_RD_LOW    = 11'b001_0000_0000,
        PH_RD_WAIT   = 11'b010_0000_0000,
        PH_RD_REC    = 11'b100_0000_0000
    } owbm_phase_t;

    localparam logic [1:0] PRES_OK    = 2'd0;
    localparam logic [1:0] PRES_NONE  = 2'd1;
    localparam logic [1:0] PRES_STUCK = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int TICK_W     = 10;

    localparam logic [2:0] CFG_RESET_LOW      = 3'd0;
    localparam logic [2:0] CFG_PRESENCE_DELAY = 3'd1;
    localparam logic [2:0] CFG_PRESENCE_WIN   = 3'd2;
    localparam logic [2:0] CFG_STUCK_LIMIT    = 3'd3;
    localparam logic [2:0] CFG_POST_PRESENCE  = 3'd4;
    localparam logic [2:0] CFG_SHORT_SLOT     = 3'd5;
    localparam logic [2:0] CFG_LONG_SLOT      = 3'd6;
    localparam logic [2:0] CFG_READ_SAMPLE    = 3'd7;

    localparam logic [9:0] RST_RESET_LOW      = 10'd600;
    localparam logic [7:0] RST_PRESENCE_DELAY = 8'd15;
    localparam logic [7:0] RST_PRESENCE_WIN   = 8'd20;
    localparam logic [9:0] RST_STUCK_LIMIT    = 10'd220;
    localparam logic [7:0] RST_POST_PRESENCE  = 8'd30;
    localparam logic [7:0] RST_SHORT_SLOT     = 8'd10;
    localparam logic [7:0] RST_LONG_SLOT      = 8'd90;
    localparam logic [7:0] RST_READ_SAMPLE    = 8'd10;

    typedef struct packed {
        logic [9:0] reset_low_ticks;
        logic [7:0] presence_delay_ticks;
        logic [7:0] presence_window_ticks;
        logic [9:0] stuck_low_limit;
        logic [7:0] post_presence_ticks;
        logic [7:0] short_slot_ticks;
        logic [7:0] long_slot_ticks;
        logic [7:0] read_sample_ticks;
    } owbm_cfg_t;

    typedef struct packed {
        owbm_action_t action;
        logic [7:0]   tx_byte;
        logic         line_level;
    } owbm_item_t;

    // shift_byte has a ninth bit: a read sample lands there before the slot-end shift
    typedef struct packed {
        owbm_phase_t       phase;
        logic [TICK_W-1:0] tick_count;
        logic [2:0]        bit_index;
        logic [8:0]        shift_byte;
        logic [1:0]        last_presence;
        logic [7:0]        held_rx;
    } owbm_state_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] presence_code;
        logic [7:0] rx_byte;
        logic       rejected;
    } owbm_res_t;

endpackage

// ----- design/owbm_if.sv -----
// Channel interfaces of the one-wire bus master: command/tick words in, result words out.
// Valid/ready handshake; depends on nothing.
`timescale 1ns / 1ps

interface owbm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] tx_byte;
    logic       line_level;

    modport source (output valid, output action, output tx_byte, output line_level,
                    input ready);
    modport sink   (input valid, input action, input tx_byte, input line_level,
                    output ready);
endinterface

interface owbm_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] presence_code;
    logic [7:0] rx_byte;
    logic       rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence_code, output rx_byte, output rejected,
                    input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence_code, input rx_byte, input rejected,
                    output ready);
endinterface

// ----- design/owbm_cfg_regs.sv -----
// Timing register file of the one-wire bus master.
// Depends on owbm_pkg for the register layout and reset values.
`timescale 1ns / 1ps

module owbm_cfg_regs
    import owbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output owbm_cfg_t             cfg
);

    owbm_cfg_t cfg_reg;
    owbm_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RESET_LOW:      cfg_next.reset_low_ticks       = cfg_wdata;
                CFG_PRESENCE_DELAY: cfg_next.presence_delay_ticks  = cfg_wdata[7:0];
                CFG_PRESENCE_WIN:   cfg_next.presence_window_ticks = cfg_wdata[7:0];
                CFG_STUCK_LIMIT:    cfg_next.stuck_low_limit       = cfg_wdata;
                CFG_POST_PRESENCE:  cfg_next.post_presence_ticks   = cfg_wdata[7:0];
                CFG_SHORT_SLOT:     cfg_next.short_slot_ticks      = cfg_wdata[7:0];
                CFG_LONG_SLOT:      cfg_next.long_slot_ticks       = cfg_wdata[7:0];
                CFG_READ_SAMPLE:    cfg_next.read_sample_ticks     = cfg_wdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_ticks       <= RST_RESET_LOW;
            cfg_reg.presence_delay_ticks  <= RST_PRESENCE_DELAY;
            cfg_reg.presence_window_ticks <= RST_PRESENCE_WIN;
            cfg_reg.stuck_low_limit       <= RST_STUCK_LIMIT;
            cfg_reg.post_presence_ticks   <= RST_POST_PRESENCE;
            cfg_reg.short_slot_ticks      <= RST_SHORT_SLOT;
            cfg_reg.long_slot_ticks       <= RST_LONG_SLOT;
            cfg_reg.read_sample_ticks     <= RST_READ_SAMPLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/owbm_step.sv -----
// Next-state and result logic of the one-wire bus master for one word.
// Depends on owbm_pkg; purely combinational, sits between the input and result registers.
`timescale 1ns / 1ps

module owbm_step
    import owbm_pkg::*;
#(
    parameter int READ_LOW_TICKS     = 2,
    parameter int READ_RECOVER_TICKS = 50
)
(
    input  owbm_cfg_t   cfg,
    input  owbm_state_t state,
    input  owbm_item_t  item,
    output owbm_state_t state_next,
    output owbm_res_t   res
);

    logic [TICK_W-1:0] limit;
    logic [TICK_W-1:0] tc_inc;
    logic [TICK_W-1:0] tc_step;
    logic              fire;
    logic              slot_last;
    logic [2:0]        bit_step;
    logic [8:0]        shift_step;
    logic              done;
    logic              rej;

    // one shared slot timer: pick the limit of the current phase
    always_comb
    begin
        unique case (state.phase)
            PH_RST_LOW:   limit = cfg.reset_low_ticks;
            PH_RST_DELAY: limit = {2'b00, cfg.presence_delay_ticks};
            PH_RST_WAIT:  limit = {2'b00, cfg.presence_window_ticks};
            PH_RST_MEAS:  limit = cfg.stuck_low_limit;
            PH_RST_POST:  limit = {2'b00, cfg.post_presence_ticks};
            PH_WR_LOW:    limit = {2'b00, state.shift_byte[0] ? cfg.short_slot_ticks
                                                              : cfg.long_slot_ticks};
            PH_WR_REC:    limit = {2'b00, state.shift_byte[0] ? cfg.long_slot_ticks
                                                              : cfg.short_slot_ticks};
            PH_RD_LOW:    limit = TICK_W'(READ_LOW_TICKS);
            PH_RD_WAIT:   limit = {2'b00, cfg.read_sample_ticks};
            PH_RD_REC:    limit = TICK_W'(READ_RECOVER_TICKS);
            default:      limit = TICK_W'(1);
        endcase
    end

    assign tc_inc     = state.tick_count + TICK_W'(1);
    assign fire       = (tc_inc >= limit);
    assign tc_step    = fire ? '0 : tc_inc;
    assign slot_last  = (state.bit_index == 3'd7);
    assign bit_step   = slot_last ? 3'd0 : state.bit_index + 3'd1;
    assign shift_step = {1'b0, state.shift_byte[8:1]};

    always_comb
    begin
        state_next = state;
        done       = 1'b0;
        rej        = 1'b0;

        unique case (item.action)
            ACT_TICK:
            begin
                if (state.phase != PH_IDLE)
                begin
                    state_next.tick_count = tc_step;
                    unique case (state.phase)
                        PH_RST_LOW:
                        begin
                            if (fire)
                                state_next.phase = PH_RST_DELAY;
                        end
                        PH_RST_DELAY:
                        begin
                            if (fire)
                                state_next.phase = PH_RST_WAIT;
                        end
                        PH_RST_WAIT:
                        begin
                            // a low line starts the presence pulse and clears the timer
                            if (!item.line_level)
                            begin
                                state_next.tick_count = '0;
                                state_next.phase      = PH_RST_MEAS;
                            end
                            else if (fire)
                            begin
                                state_next.last_presence = PRES_NONE;
                                done                     = 1'b1;
                            end
                        end
                        PH_RST_MEAS:
                        begin
                            if (item.line_level)
                            begin
                                state_next.tick_count = '0;
                                state_next.phase      = PH_RST_POST;
                            end
                            else if (fire)
                            begin
                                state_next.last_presence = PRES_STUCK;
                                done                     = 1'b1;
                            end
                        end
                        PH_RST_POST:
                        begin
                            if (fire)
                            begin
                                state_next.last_presence = PRES_OK;
                                done                     = 1'b1;
                            end
                        end
                        PH_WR_LOW:
                        begin
                            if (fire)
                                state_next.phase = PH_WR_REC;
                        end
                        PH_WR_REC:
                        begin
                            if (fire)
                            begin
                                state_next.shift_byte = shift_step;
                                state_next.bit_index  = bit_step;
                                if (slot_last)
                                    done = 1'b1;
                                else
                                    state_next.phase = PH_WR_LOW;
                            end
                        end
                        PH_RD_LOW:
                        begin
                            if (fire)
                                state_next.phase = PH_RD_WAIT;
                        end
                        PH_RD_WAIT:
                        begin
                            // park the sample in the top bit; the slot-end shift moves it to bit 7
                            if (fire)
                            begin
                                state_next.shift_byte = {item.line_level,
                                                         state.shift_byte[7:1], 1'b0};
                                state_next.phase      = PH_RD_REC;
                            end
                        end
                        PH_RD_REC:
                        begin
                            if (fire)
                            begin
                                state_next.shift_byte = shift_step;
                                state_next.bit_index  = bit_step;
                                if (slot_last)
                                begin
                                    state_next.held_rx = shift_step[7:0];
                                    done               = 1'b1;
                                end
                                else
                                begin
                                    state_next.phase = PH_RD_LOW;
                                end
                            end
                        end
                        default:
                        begin
                            state_next.tick_count = state.tick_count;
                            state_next.phase      = PH_IDLE;
                        end
                    endcase

                    if (done)
                    begin
                        state_next.phase      = PH_IDLE;
                        state_next.tick_count = '0;
                    end
                end
            end
            ACT_RESET, ACT_WRITE, ACT_READ:
            begin
                if (state.phase != PH_IDLE)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    state_next.tick_count = '0;
                    state_next.bit_index  = '0;
                    priority case (item.action)
                        ACT_RESET:
                            state_next.phase = PH_RST_LOW;
                        ACT_WRITE:
                        begin
                            state_next.shift_byte = {1'b0, item.tx_byte};
                            state_next.phase      = PH_WR_LOW;
                        end
                        default:
                        begin
                            state_next.shift_byte = '0;
                            state_next.phase      = PH_RD_LOW;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    always_comb
    begin
        res.drive_low     = (state_next.phase == PH_RST_LOW) ||
                            (state_next.phase == PH_WR_LOW)  ||
                            (state_next.phase == PH_RD_LOW);
        res.busy_res      = (state_next.phase != PH_IDLE);
        res.done_res      = done;
        res.presence_code = state_next.last_presence;
        res.rx_byte       = state_next.held_rx;
        res.rejected      = rej;
    end

endmodule

// ----- design/one_wire_bus_master_core.sv -----
// Top level of the one-wire bus master: input register, step logic, result register.
// Depends on owbm_pkg, owbm_if, owbm_cfg_regs, owbm_step and the assertion macro header.
//
//   channel  | dir | word                                    | accepted when
//   ---------+-----+-----------------------------------------+----------------------
//   in_ch    | in  | action, tx_byte, line_level             | valid && ready
//   out_ch   | out | drive_low, busy_res, done_res,          | valid && ready
//            |     | presence_code, rx_byte, rejected        |
//   cfg      | in  | cfg_index, cfg_wdata                    | cfg_we
//
// One result word per input word; a taken word goes into the input register, then through
// owbm_step into the result register, which drives the output word and its valid.
// Sustained rate is one word per cycle while the output is not stalled: owbm_step is combinational.
// Reset is asynchronous: phase idle, counters and held bytes zero, timing registers
// at their defaults; no clearing pass.
// A stalled output holds its word; the input register can take one more word and then drops ready.
`timescale 1ns / 1ps
`include "one_wire_bus_master_core_defines.svh"

module one_wire_bus_master_core
    import owbm_pkg::*;
#(
    parameter int READ_LOW_TICKS     = 2,
    parameter int READ_RECOVER_TICKS = 50
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    owbm_in_if.sink               in_ch,
    owbm_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    owbm_cfg_t   cfg;
    owbm_item_t  item_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    owbm_state_t state_reg;
    owbm_state_t state_next;
    owbm_res_t   res_next;
    owbm_res_t   res_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        step_fire;
    logic        in_take;

    owbm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    owbm_step #(
        .READ_LOW_TICKS     (READ_LOW_TICKS),
        .READ_RECOVER_TICKS (READ_RECOVER_TICKS)
    ) u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    // advance the held word whenever the result slot is free or being emptied
    assign step_fire   = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || step_fire;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (step_fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step_fire)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
            state_reg.phase          <= PH_IDLE;
            state_reg.tick_count     <= '0;
            state_reg.bit_index      <= '0;
            state_reg.shift_byte     <= '0;
            state_reg.last_presence  <= PRES_OK;
            state_reg.held_rx        <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_fire)
                state_reg <= state_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.action     <= owbm_action_t'(in_ch.action);
            item_reg.tx_byte    <= in_ch.tx_byte;
            item_reg.line_level <= in_ch.line_level;
        end
        if (step_fire)
            res_reg <= res_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.drive_low     = res_reg.drive_low;
    assign out_ch.busy_res      = res_reg.busy_res;
    assign out_ch.done_res      = res_reg.done_res;
    assign out_ch.presence_code = res_reg.presence_code;
    assign out_ch.rx_byte       = res_reg.rx_byte;
    assign out_ch.rejected      = res_reg.rejected;

    `OWBM_ASSERT(a_idle_counters_clear,
        (state_reg.phase == PH_IDLE) |-> (state_reg.tick_count == '0 && state_reg.bit_index == '0),
        "idle phase with a live timer or slot count")
    `OWBM_ASSERT(a_done_returns_idle,
        (step_fire && res_next.done_res) |=> (state_reg.phase == PH_IDLE && !res_reg.busy_res),
        "finished operation did not return to idle")
    `OWBM_ASSERT(a_reject_only_busy,
        (step_fire && res_next.rejected) |-> (state_reg.phase != PH_IDLE && state_next == state_reg),
        "command rejected while idle")
    `OWBM_ASSERT(a_state_holds_on_stall,
        (!step_fire) |=> $stable(state_reg),
        "bus state moved without a word")

endmodule

// ----- tb/one_wire_bus_master_core_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for one_wire_bus_master_core: queued command and tick words with
// random sender bursts and receiver stalls, each result word checked against a cycle model.
// Depends on owbm_pkg and the channel interfaces of owbm_if.
module one_wire_bus_master_core_tb;
    import owbm_pkg::*;

    localparam int RD_LOW_TICKS     = 2;
    localparam int RD_RECOVER_TICKS = 50;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int QUIET_LIMIT      = 3000;
    localparam int NEVER            = 4000;

    typedef struct packed {
        owbm_phase_t       phase;
        logic [TICK_W-1:0] ticks;
        logic [2:0]        bit_idx;
        logic [8:0]        shift;
        logic [1:0]        presence;
        logic [7:0]        rx_hold;
    } bus_state_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    owbm_in_if  in_ch();
    owbm_out_if out_ch();

    logic [CFG_DATA_W-1:0] timing [8];
    logic [CFG_DATA_W-1:0] next_timing [8];
    bus_state_t            chk_st;
    bus_state_t            plan_st;
    owbm_item_t            pending_words [$];
    owbm_res_t             expected_res [$];

    int   words_planned = 0;
    int   words_taken   = 0;
    int   busy_words    = 0;
    int   fail_count    = 0;
    int   quiet_cycles  = 0;
    int   answer_at;
    int   low_len;
    int   wait_seen;
    int   meas_seen;
    int   burst_left    = 1;
    int   gap_left      = 0;
    int   stall_mode    = 0;
    int   mode_left     = 0;
    int   rx_cycle      = 0;
    int   hold_left     = 0;
    logic hold_off_req  = 1'b0;
    logic hold_off_done = 1'b0;
    logic in_accepted   = 1'b0;

    owbm_item_t drv_word;
    owbm_item_t mon_word;
    owbm_res_t  want;
    owbm_res_t  got;

    one_wire_bus_master_core #(
        .READ_LOW_TICKS     (RD_LOW_TICKS),
        .READ_RECOVER_TICKS (RD_RECOVER_TICKS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    task automatic count_tick(inout logic [TICK_W-1:0] cnt, input logic [9:0] lim,
                              output logic hit);
        cnt = cnt + 1'b1;
        hit = (cnt >= lim);
        if (hit)
            cnt = '0;
    endtask

    task automatic close_slot(inout bus_state_t st, output logic last);
        st.shift = st.shift >> 1;
        last = (st.bit_idx == 3'd7);
        st.bit_idx = st.bit_idx + 1'b1;
    endtask

    // One word through the bus master: advance the phase timer or start/reject a command.
    task automatic bus_step(inout bus_state_t st, input owbm_item_t w, output owbm_res_t r);
        logic hit;
        logic last;
        logic fin;
        logic rej;
        fin = 1'b0;
        rej = 1'b0;
        if (w.action == ACT_TICK)
        begin
            if (st.phase != PH_IDLE)
            begin
                case (st.phase)
                    PH_RST_LOW:
                    begin
                        count_tick(st.ticks, timing[CFG_RESET_LOW], hit);
                        if (hit)
                            st.phase = PH_RST_DELAY;
                    end
                    PH_RST_DELAY:
                    begin
                        count_tick(st.ticks, timing[CFG_PRESENCE_DELAY], hit);
                        if (hit)
                            st.phase = PH_RST_WAIT;
                    end
                    PH_RST_WAIT:
                    begin
                        if (!w.line_level)
                        begin
                            st.ticks = '0;
                            st.phase = PH_RST_MEAS;
                        end
                        else
                        begin
                            count_tick(st.ticks, timing[CFG_PRESENCE_WIN], hit);
                            if (hit)
                            begin
                                st.presence = PRES_NONE;
                                fin = 1'b1;
                            end
                        end
                    end
                    PH_RST_MEAS:
                    begin
                        if (w.line_level)
                        begin
                            st.ticks = '0;
                            st.phase = PH_RST_POST;
                        end
                        else
                        begin
                            count_tick(st.ticks, timing[CFG_STUCK_LIMIT], hit);
                            if (hit)
                            begin
                                st.presence = PRES_STUCK;
                                fin = 1'b1;
                            end
                        end
                    end
                    PH_RST_POST:
                    begin
                        count_tick(st.ticks, timing[CFG_POST_PRESENCE], hit);
                        if (hit)
                        begin
                            st.presence = PRES_OK;
                            fin = 1'b1;
                        end
                    end
                    PH_WR_LOW:
                    begin
                        count_tick(st.ticks, st.shift[0] ? timing[CFG_SHORT_SLOT]
                                                         : timing[CFG_LONG_SLOT], hit);
                        if (hit)
                            st.phase = PH_WR_REC;
                    end
                    PH_WR_REC:
                    begin
                        count_tick(st.ticks, st.shift[0] ? timing[CFG_LONG_SLOT]
                                                         : timing[CFG_SHORT_SLOT], hit);
                        if (hit)
                        begin
                            close_slot(st, last);
                            if (last)
                                fin = 1'b1;
                            else
                                st.phase = PH_WR_LOW;
                        end
                    end
                    PH_RD_LOW:
                    begin
                        count_tick(st.ticks, 10'(RD_LOW_TICKS), hit);
                        if (hit)
                            st.phase = PH_RD_WAIT;
                    end
                    PH_RD_WAIT:
                    begin
                        count_tick(st.ticks, timing[CFG_READ_SAMPLE], hit);
                        if (hit)
                        begin
                            // park the sample above bit 7; the slot-end shift drops it in
                            st.shift = {w.line_level, st.shift[7:1], 1'b0};
                            st.phase = PH_RD_REC;
                        end
                    end
                    PH_RD_REC:
                    begin
                        count_tick(st.ticks, 10'(RD_RECOVER_TICKS), hit);
                        if (hit)
                        begin
                            close_slot(st, last);
                            if (last)
                            begin
                                st.rx_hold = st.shift[7:0];
                                fin = 1'b1;
                            end
                            else
                                st.phase = PH_RD_LOW;
                        end
                    end
                    default:
                        st.phase = PH_IDLE;
                endcase
                if (fin)
                begin
                    st.phase = PH_IDLE;
                    st.ticks = '0;
                end
            end
        end
        else if (st.phase != PH_IDLE)
            rej = 1'b1;
        else
        begin
            st.ticks   = '0;
            st.bit_idx = '0;
            case (w.action)
                ACT_RESET:
                    st.phase = PH_RST_LOW;
                ACT_WRITE:
                begin
                    st.shift = {1'b0, w.tx_byte};
                    st.phase = PH_WR_LOW;
                end
                default:
                begin
                    st.shift = '0;
                    st.phase = PH_RD_LOW;
                end
            endcase
        end
        r.drive_low     = (st.phase == PH_RST_LOW || st.phase == PH_WR_LOW ||
                           st.phase == PH_RD_LOW);
        r.busy_res      = (st.phase != PH_IDLE);
        r.done_res      = fin;
        r.presence_code = st.presence;
        r.rx_byte       = st.rx_hold;
        r.rejected      = rej;
    endtask

    task automatic report_mismatch(string msg);
        fail_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Queue one word and run it through the planning copy so later line levels fit the phase.
    task automatic plan_item(owbm_action_t act, logic [7:0] tx, logic lvl);
        owbm_item_t w;
        owbm_res_t  unused;
        w.action     = act;
        w.tx_byte    = tx;
        w.line_level = lvl;
        if (act != ACT_TICK || plan_st.phase != PH_IDLE)
            busy_words++;
        bus_step(plan_st, w, unused);
        pending_words.push_back(w);
        words_planned++;
    endtask

    task automatic plan_tick();
        logic lvl;
        lvl = 1'($urandom_range(0, 1));
        if (plan_st.phase == PH_RST_WAIT)
        begin
            lvl = (wait_seen < answer_at);
            wait_seen++;
        end
        else if (plan_st.phase == PH_RST_MEAS)
        begin
            lvl = (meas_seen >= low_len);
            meas_seen++;
        end
        plan_item(ACT_TICK, 8'($urandom), lvl);
    endtask

    // ans: ticks into the presence window before the device pulls low; low: its pulse length
    task automatic plan_start(owbm_action_t act, logic [7:0] tx, int ans, int low);
        answer_at = ans;
        low_len   = low;
        wait_seen = 0;
        meas_seen = 0;
        plan_item(act, tx, 1'($urandom_range(0, 1)));
    endtask

    task automatic plan_finish();
        while (plan_st.phase != PH_IDLE)
        begin
            if ($urandom_range(0, 99) < 3)
                plan_item(owbm_action_t'($urandom_range(1, 3)), 8'($urandom),
                          1'($urandom_range(0, 1)));
            else
                plan_tick();
        end
        if ($urandom_range(0, 9) == 0)
            plan_tick();
    endtask

    // Resets and writes only; a read costs hundreds of words and is planned on its own.
    task automatic plan_random(int budget);
        int start;
        int pick;
        int ans;
        int low;
        start = busy_words;
        while (busy_words - start < budget)
        begin
            pick = $urandom_range(0, 99);
            ans  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, timing[CFG_PRESENCE_WIN])
                                              : NEVER;
            low  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, timing[CFG_STUCK_LIMIT])
                                               : NEVER;
            if (pick < 55)
                plan_start(ACT_RESET, 8'($urandom), ans, low);
            else
                plan_start(ACT_WRITE, 8'($urandom), ans, low);
            plan_finish();
        end
    endtask

    task automatic load_timing();
        int k;
        for (k = 0; k < 8; k++)
        begin
            @(negedge clk);
            cfg_we    = 1'b1;
            cfg_index = k[CFG_IDX_W-1:0];
            cfg_wdata = next_timing[k];
            timing[k] = (k == CFG_RESET_LOW || k == CFG_STUCK_LIMIT) ? next_timing[k]
                                                                     : {2'b00, next_timing[k][7:0]};
        end
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (words_taken != words_planned || expected_res.size() != 0);
        // let the last result handshake settle before the next section
        repeat (4) @(negedge clk);
    endtask

    // Sender: bursts of words with random gaps, hold a word until it is taken.
    always @(negedge clk)
    begin
        if (!in_ch.valid || in_accepted)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                drv_word = pending_words.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.action     <= drv_word.action;
                in_ch.tx_byte    <= drv_word.tx_byte;
                in_ch.line_level <= drv_word.line_level;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver: stall pattern switches every so often; one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_off_req && !hold_off_done)
        begin
            hold_left     = HOLD_OFF_CYCLES;
            hold_off_done = 1'b1;
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end
        else
            mode_left--;
        rx_cycle++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       out_ch.ready <= 1'($urandom_range(0, 1));
                default: out_ch.ready <= (rx_cycle % 3 != 0);
            endcase
        end
    end

    // Monitor: predict on every accepted word, compare every accepted result word.
    always @(posedge clk)
    begin
        in_accepted <= in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            mon_word.action     = owbm_action_t'(in_ch.action);
            mon_word.tx_byte    = in_ch.tx_byte;
            mon_word.line_level = in_ch.line_level;
            bus_step(chk_st, mon_word, want);
            expected_res.push_back(want);
            words_taken++;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.drive_low     = out_ch.drive_low;
            got.busy_res      = out_ch.busy_res;
            got.done_res      = out_ch.done_res;
            got.presence_code = out_ch.presence_code;
            got.rx_byte       = out_ch.rx_byte;
            got.rejected      = out_ch.rejected;
            if (expected_res.size() == 0)
                report_mismatch("result word with no input word pending");
            else
            begin
                want = expected_res.pop_front();
                if (got.drive_low !== want.drive_low)
                    report_mismatch($sformatf("drive_low expected %0b got %0b",
                                              want.drive_low, got.drive_low));
                if (got.busy_res !== want.busy_res)
                    report_mismatch($sformatf("busy_res expected %0b got %0b",
                                              want.busy_res, got.busy_res));
                if (got.done_res !== want.done_res)
                    report_mismatch($sformatf("done_res expected %0b got %0b",
                                              want.done_res, got.done_res));
                if (got.presence_code !== want.presence_code)
                    report_mismatch($sformatf("presence_code expected %0d got %0d",
                                              want.presence_code, got.presence_code));
                if (got.rx_byte !== want.rx_byte)
                    report_mismatch($sformatf("rx_byte expected %02h got %02h",
                                              want.rx_byte, got.rx_byte));
                if (got.rejected !== want.rejected)
                    report_mismatch($sformatf("rejected expected %0b got %0b",
                                              want.rejected, got.rejected));
            end
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int ph;
        int k;
        in_ch.valid      = 1'b0;
        in_ch.action     = ACT_TICK;
        in_ch.tx_byte    = 8'h00;
        in_ch.line_level = 1'b1;
        out_ch.ready     = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        rst_n            = 1'b0;
        timing[CFG_RESET_LOW]      = RST_RESET_LOW;
        timing[CFG_PRESENCE_DELAY] = {2'b00, RST_PRESENCE_DELAY};
        timing[CFG_PRESENCE_WIN]   = {2'b00, RST_PRESENCE_WIN};
        timing[CFG_STUCK_LIMIT]    = RST_STUCK_LIMIT;
        timing[CFG_POST_PRESENCE]  = {2'b00, RST_POST_PRESENCE};
        timing[CFG_SHORT_SLOT]     = {2'b00, RST_SHORT_SLOT};
        timing[CFG_LONG_SLOT]      = {2'b00, RST_LONG_SLOT};
        timing[CFG_READ_SAMPLE]    = {2'b00, RST_READ_SAMPLE};
        chk_st       = '0;
        chk_st.phase = PH_IDLE;
        plan_st      = chk_st;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Register defaults: ticks while idle, a reset with commands rejected while busy.
        plan_item(ACT_TICK, 8'h00, 1'b0);
        plan_item(ACT_TICK, 8'hFF, 1'b1);
        plan_start(ACT_RESET, 8'h00, 4, 6);
        plan_item(ACT_WRITE, 8'hA5, 1'b0);
        plan_item(ACT_READ, 8'h5A, 1'b1);
        plan_item(ACT_RESET, 8'hFF, 1'b0);
        plan_finish();
        wait_idle();

        // Every timing register zero: each phase ends after a single tick.
        for (k = 0; k < 8; k++)
            next_timing[k] = '0;
        load_timing();
        @(posedge clk);
        plan_start(ACT_WRITE, 8'h00, 0, 0);
        plan_finish();
        plan_start(ACT_WRITE, 8'hFF, 0, 0);
        plan_finish();
        plan_start(ACT_RESET, 8'h00, 0, 0);
        plan_finish();
        plan_start(ACT_RESET, 8'h00, NEVER, 0);
        plan_finish();
        plan_start(ACT_RESET, 8'h00, 0, NEVER);
        plan_finish();
        wait_idle();

        for (k = 0; k < 8; k++)
            next_timing[k] = 10'd1;
        load_timing();
        @(posedge clk);
        plan_random(40);
        wait_idle();

        // Short random timings, stray upper bits on the 8-bit registers now and then; one pass adds a read.
        for (ph = 0; ph < 5; ph++)
        begin
            for (k = 0; k < 8; k++)
            begin
                if (k == CFG_RESET_LOW || k == CFG_STUCK_LIMIT)
                    next_timing[k] = 10'($urandom_range(0, 12));
                else
                begin
                    next_timing[k] = 10'($urandom_range(0, 6));
                    if ($urandom_range(0, 3) == 0)
                        next_timing[k][9:8] = 2'($urandom_range(1, 3));
                end
            end
            load_timing();
            @(posedge clk);
            if (ph == 1)
            begin
                plan_start(ACT_READ, 8'($urandom), NEVER, NEVER);
                plan_finish();
            end
            plan_random(30);
            // stall the result side while words keep coming
            if (ph == 1)
                hold_off_req = 1'b1;
            wait_idle();
        end

        // Wide presence window and stuck limit around a short reset pulse.
        for (k = 0; k < 8; k++)
            next_timing[k] = 10'h3FF;
        next_timing[CFG_RESET_LOW]      = 10'd1;
        next_timing[CFG_PRESENCE_DELAY] = 10'd1;
        next_timing[CFG_POST_PRESENCE]  = 10'd1;
        load_timing();
        @(posedge clk);
        plan_start(ACT_RESET, 8'($urandom), 7, 9);
        plan_finish();
        wait_idle();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
